[design/loop_segment_sample_player_macros.svh]
// Assertion macros for the loop segment sample player.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LOOP_SEGMENT_SAMPLE_PLAYER_MACROS_SVH
`define LOOP_SEGMENT_SAMPLE_PLAYER_MACROS_SVH
`ifndef SYNTH
`define LSSP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lssp: same-cycle check failed");
`define LSSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lssp: next-cycle check failed");
`else
`define LSSP_ASSERT_SAME(lbl, ante, cons)
`define LSSP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[design/lssp_pkg.sv]
// Package for the loop segment sample player: constants, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package lssp_pkg;

    localparam int LSSP_MAX_FRAMES  = 131072;
    localparam int LSSP_SAMPLE_BITS = 16;

    localparam int ADDR_W    = 18;
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 16;
    localparam int PHASE_W   = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 18;
    localparam int CHAN_W    = 2;
    localparam int SHIFT_W   = 3;
    localparam int MULT_W    = 7;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_CLK,
        ST_MOD_LEN,
        ST_RD_L,
        ST_RD_R,
        ST_FIN
    } lssp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lssp_mod_stat_t;

endpackage

[design/lssp_ifs.sv]
// Handshake channels of the loop segment sample player.
// Depends on lssp_pkg for field widths.
`timescale 1ns / 1ps
interface lssp_cmd_if import lssp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [ADDR_W-1:0]          sample_address;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [MAG_W-1:0]           magnitude;
    logic signed [PHASE_W-1:0]  phase;

    modport source (output valid, func, sample_address, sample_value, magnitude, phase,
                    input ready);
    modport sink (input valid, func, sample_address, sample_value, magnitude, phase,
                  output ready);
endinterface

interface lssp_rsp_if import lssp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, left_sample, right_sample, input ready);
    modport sink (input valid, left_sample, right_sample, output ready);
endinterface

[design/lssp_mod.sv]
// Shared iterative remainder unit, one restoring step per cycle.
// Depends on lssp_pkg.
`timescale 1ns / 1ps
module lssp_mod import lssp_pkg::*; #(
    parameter int MAX_FRAMES = LSSP_MAX_FRAMES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [$clog2(MAX_FRAMES + 1)-1:0]     num,
    input  logic [$clog2(MAX_FRAMES + 1)-1:0]     den,
    output logic [$clog2(MAX_FRAMES + 1)-1:0]     rem,
    output lssp_mod_stat_t                        stat
);
    localparam int FW  = $clog2(MAX_FRAMES + 1);
    localparam int CNW = $clog2(FW + 1);

    logic [FW-1:0]  rem_reg, rem_next;
    logic [FW-1:0]  num_reg;
    logic [FW-1:0]  den_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [FW:0]    trial;

    always_comb
    begin
        trial = {rem_reg, num_reg[FW-1]};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = FW'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = FW'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNW'(FW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNW'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[FW-2:0], 1'b0};
        end
    end

    assign rem       = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[design/lssp_store.sv]
// Sample store: single write port, single registered read port.
// Depends on lssp_pkg.
`timescale 1ns / 1ps
module lssp_store import lssp_pkg::*; #(
    parameter int MAX_FRAMES  = LSSP_MAX_FRAMES,
    parameter int SAMPLE_BITS = LSSP_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [$clog2(2 * MAX_FRAMES)-1:0]  waddr,
    input  logic [SAMPLE_W-1:0]                wdata,
    input  logic                               re,
    input  logic [$clog2(2 * MAX_FRAMES)-1:0]  raddr,
    output logic [SAMPLE_W-1:0]                rdata
);
    localparam int DEPTH = 2 * MAX_FRAMES;

    logic [SAMPLE_BITS-1:0] mem [0:DEPTH-1];
    logic [SAMPLE_BITS-1:0] wword;
    logic [SAMPLE_BITS-1:0] rdata_reg;

    // keep SAMPLE_BITS low bits; missing bits read back as zero
    always_comb
    begin
        for (int i = 0; i < SAMPLE_BITS; i++)
        begin
            wword[i] = (i < SAMPLE_W) ? wdata[i] : 1'b0;
        end
        for (int j = 0; j < SAMPLE_W; j++)
        begin
            rdata[j] = (j < SAMPLE_BITS) ? rdata_reg[j] : 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wword;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

[design/loop_segment_sample_player.sv]
// Top level of the loop segment sample player: sequencer, config, output register.
// Depends on lssp_pkg, lssp_ifs, lssp_mod, lssp_store and the macros header.
//
//  channel  | dir | handshake           | payload
//  cmd      | in  | valid/ready         | func, sample_address, sample_value, magnitude, phase
//  rsp      | out | valid/ready         | left_sample, right_sample
//  cfg      | in  | cfg_wr_en           | cfg_index, cfg_data
//
// Load item: written to the store on accept if its address is in range.
// Render item: two passes through the one-bit-per-cycle remainder unit, then two reads
// on the single store port. Input not ready while a render runs.
// Reset clears clock and valid and sets both config registers to 1; store contents are undefined until loaded.
// A result waiting at rsp stalls only the final step of the next render.
`timescale 1ns / 1ps
`include "loop_segment_sample_player_macros.svh"
module loop_segment_sample_player import lssp_pkg::*; #(
    parameter int MAX_FRAMES  = LSSP_MAX_FRAMES,
    parameter int SAMPLE_BITS = LSSP_SAMPLE_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lssp_cmd_if.sink             cmd,
    lssp_rsp_if.source           rsp,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int FW = $clog2(MAX_FRAMES + 1);
    localparam int CW = $clog2(MAX_FRAMES);
    localparam int AW = $clog2(2 * MAX_FRAMES);
    localparam int PW = FW + MULT_W;

    lssp_state_t state_reg, state_next;

    logic [CFG_W-1:0]  frame_count_reg;
    logic [CHAN_W-1:0] channel_count_reg;
    logic [CW-1:0]     fc_reg;

    logic [FW-1:0]      frames_reg;
    logic               stereo_reg;
    logic [SHIFT_W-1:0] n_reg;
    logic [FW-1:0]      length_reg;
    logic [PW-1:0]      prod_reg;
    logic [CW-1:0]      idx_reg;
    logic [SAMPLE_W-1:0] left_hold_reg;
    logic               rsp_valid_reg;
    logic [SAMPLE_W-1:0] left_reg, right_reg;

    logic [FW-1:0]      frames_eff;
    logic [SHIFT_W-1:0] n_in;
    logic [4:0]         ph_shift;
    logic [MAG_W-1:0]   ph_shifted;
    logic [MULT_W-1:0]  m_in;
    logic [FW-1:0]      length_raw;
    logic [FW-1:0]      length_next;
    logic [PW-1:0]      prod_next;
    logic [FW:0]        idx_sum;
    logic [FW-1:0]      idx_next;
    logic [AW-1:0]      base_addr;

    logic               accept;
    logic               render_accept;
    logic               out_load;
    logic               mod_start;
    logic [FW-1:0]      mod_num, mod_den, mod_rem;
    lssp_mod_stat_t     mod_stat;
    logic               st_we, st_re;
    logic [AW-1:0]      st_waddr, st_raddr;
    logic [SAMPLE_W-1:0] st_rdata;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg   <= CFG_W'(1);
            channel_count_reg <= CHAN_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_COUNT:   frame_count_reg   <= cfg_data;
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // render parameters from the incoming item
    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            frames_eff = FW'(1);
        end
        else if (32'(frame_count_reg) > 32'(MAX_FRAMES))
        begin
            frames_eff = FW'(MAX_FRAMES);
        end
        else
        begin
            frames_eff = FW'(frame_count_reg);
        end
        n_in       = cmd.magnitude[MAG_W-1 -: SHIFT_W];
        ph_shift   = 5'd16 - {2'b00, n_in};
        ph_shifted = cmd.phase[MAG_W-1:0] >> ph_shift;
        m_in       = cmd.phase[PHASE_W-1] ? '0 : ph_shifted[MULT_W-1:0];
        length_raw = frames_eff >> n_in;
        length_next = (length_raw == '0) ? FW'(1) : length_raw;
        prod_next  = PW'(frames_eff) * PW'(m_in);
    end

    // wrap of clock-in-segment plus offset, at most one subtract
    always_comb
    begin
        idx_sum = {1'b0, mod_rem} + {1'b0, FW'(prod_reg >> n_reg)};
        if (idx_sum >= {1'b0, frames_reg})
        begin
            idx_next = FW'(idx_sum - {1'b0, frames_reg});
        end
        else
        begin
            idx_next = FW'(idx_sum);
        end
        base_addr = stereo_reg ? AW'({idx_reg, 1'b0}) : AW'(idx_reg);
    end

    assign accept        = cmd.valid && cmd.ready;
    assign render_accept = accept && (cmd.func == FUNC_RENDER);
    assign out_load      = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (cmd.valid && cmd.func == FUNC_RENDER) state_next = ST_MOD_CLK;
            ST_MOD_CLK: if (mod_stat.done) state_next = ST_MOD_LEN;
            ST_MOD_LEN: if (mod_stat.done) state_next = ST_RD_L;
            ST_RD_L:    state_next = ST_RD_R;
            ST_RD_R:    state_next = ST_FIN;
            ST_FIN:     if (!rsp_valid_reg || rsp.ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        mod_start = 1'b0;
        mod_num   = FW'(fc_reg) + FW'(1);
        mod_den   = frames_eff;
        st_re     = 1'b0;
        st_raddr  = base_addr;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                mod_start = cmd.valid && (cmd.func == FUNC_RENDER);
            end
            ST_MOD_CLK:
            begin
                mod_start = mod_stat.done;
                mod_num   = mod_rem;
                mod_den   = length_reg;
            end
            ST_RD_L:
            begin
                st_re = 1'b1;
            end
            ST_RD_R:
            begin
                st_re    = 1'b1;
                st_raddr = base_addr | {{(AW-1){1'b0}}, stereo_reg};
            end
            default: ;
        endcase
    end

    assign st_we    = accept && (cmd.func == FUNC_LOAD) &&
                      (32'(cmd.sample_address) < 32'(2 * MAX_FRAMES));
    assign st_waddr = AW'(cmd.sample_address);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fc_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MOD_CLK && mod_stat.done)
            begin
                fc_reg <= CW'(mod_rem);
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (render_accept)
        begin
            frames_reg <= frames_eff;
            stereo_reg <= channel_count_reg[1];
            n_reg      <= n_in;
            length_reg <= length_next;
            prod_reg   <= prod_next;
        end
        if (state_reg == ST_MOD_LEN && mod_stat.done)
        begin
            idx_reg <= CW'(idx_next);
        end
        if (state_reg == ST_RD_R)
        begin
            left_hold_reg <= st_rdata;
        end
        if (out_load)
        begin
            left_reg  <= left_hold_reg;
            right_reg <= st_rdata;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.left_sample  = left_reg;
    assign rsp.right_sample = right_reg;

    lssp_mod #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .num   (mod_num),
        .den   (mod_den),
        .rem   (mod_rem),
        .stat  (mod_stat)
    );

    lssp_store #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (cmd.sample_value),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    `LSSP_ASSERT_SAME(a_clock_in_loop, state_reg == ST_MOD_LEN, FW'(fc_reg) < frames_reg)
    `LSSP_ASSERT_SAME(a_index_in_loop, state_reg == ST_RD_L, FW'(idx_reg) < frames_reg)
    `LSSP_ASSERT_SAME(a_mod_owned, mod_stat.busy, state_reg == ST_MOD_CLK || state_reg == ST_MOD_LEN)
    `LSSP_ASSERT_NEXT(a_result_from_fin, !rsp_valid_reg && state_reg != ST_FIN, !rsp_valid_reg)

endmodule

[sim/loop_segment_sample_player_tb.sv]
`timescale 1ns / 1ps
// Testbench for loop_segment_sample_player: sends load and render items, predicts
// each rendered frame and checks left/right samples against it.
// Depends on lssp_pkg, lssp_ifs and the player RTL.
module loop_segment_sample_player_tb;
    import lssp_pkg::*;

    localparam int STORE_WORDS   = 2 * LSSP_MAX_FRAMES;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 120;
    localparam int LOOP_ITEMS    = 90;

    typedef struct {
        logic                func;
        logic [ADDR_W-1:0]   sample_address;
        logic [SAMPLE_W-1:0] sample_value;
        logic [MAG_W-1:0]    magnitude;
        logic [PHASE_W-1:0]  phase;
    } player_cmd_t;

    typedef struct {
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] right_sample;
    } stereo_frame_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    lssp_cmd_if cmd_ch ();
    lssp_rsp_if rsp_ch ();

    loop_segment_sample_player uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the player
    logic [SAMPLE_W-1:0] sample_mem [STORE_WORDS];
    bit                  loaded [STORE_WORDS];
    int unsigned         play_clock;
    logic [CFG_W-1:0]    frame_count_reg;
    logic [1:0]          channel_count_reg;
    stereo_frame_t       expected_frames[$];

    int  errors;
    int  frames_checked;
    int  loads_sent;
    int  renders_sent;
    int  settings_used;
    int  idle_cycles;
    int  stall_left;
    int  hold_request;
    bit  sender_calm;
    bit  receiver_calm;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned active_frames();
        if (frame_count_reg == 0)
            return 1;
        if (frame_count_reg > LSSP_MAX_FRAMES)
            return LSSP_MAX_FRAMES;
        return frame_count_reg;
    endfunction

    function automatic int unsigned active_channels();
        return (channel_count_reg >= 2) ? 2 : 1;
    endfunction

    // frame index the next render reads; the clock is not moved here
    function automatic int unsigned next_read_index(logic [MAG_W-1:0] mag,
                                                    logic [PHASE_W-1:0] ph);
        int unsigned     frames;
        int unsigned     n;
        int unsigned     seg_len;
        int unsigned     offset;
        int unsigned     step;
        int unsigned     clock_next;
        longint unsigned prod;
        frames = active_frames();
        n = mag[MAG_W-1 -: 3];
        seg_len = frames >> n;
        if (seg_len == 0)
            seg_len = 1;
        offset = 0;
        if (!ph[PHASE_W-1])
        begin
            step = int'(ph[PHASE_W-2:0]) >> (16 - n);
            prod = longint'(frames) * step;
            offset = int'(prod >> n);
        end
        clock_next = (play_clock + 1) % frames;
        return ((clock_next % seg_len) + offset) % frames;
    endfunction

    function automatic void model_accept(player_cmd_t c);
        int unsigned   base;
        stereo_frame_t f;
        if (c.func == FUNC_LOAD)
        begin
            sample_mem[c.sample_address] = c.sample_value;
            loaded[c.sample_address] = 1'b1;
            loads_sent++;
        end
        else
        begin
            base = active_channels() * next_read_index(c.magnitude, c.phase);
            play_clock = (play_clock + 1) % active_frames();
            f.left_sample = sample_mem[base];
            f.right_sample = sample_mem[base + active_channels() - 1];
            expected_frames.push_back(f);
            renders_sent++;
        end
    endfunction

    function automatic player_cmd_t make_load(int unsigned addr, logic [SAMPLE_W-1:0] value);
        player_cmd_t c;
        c.func = FUNC_LOAD;
        c.sample_address = addr;
        c.sample_value = value;
        c.magnitude = $urandom;
        c.phase = $urandom;
        return c;
    endfunction

    task automatic send_item(player_cmd_t c);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 60)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid          <= 1'b1;
        cmd_ch.func           <= c.func;
        cmd_ch.sample_address <= c.sample_address;
        cmd_ch.sample_value   <= c.sample_value;
        cmd_ch.magnitude      <= c.magnitude;
        cmd_ch.phase          <= c.phase;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        model_accept(c);
    endtask

    // render one frame, loading first any word it would read that was never written
    task automatic play_frame(logic [MAG_W-1:0] mag, logic [PHASE_W-1:0] ph);
        int unsigned base;
        player_cmd_t c;
        base = active_channels() * next_read_index(mag, ph);
        for (int unsigned a = base; a < base + active_channels(); a++)
        begin
            if (!loaded[a])
                send_item(make_load(a, $urandom));
        end
        c.func = FUNC_RENDER;
        c.sample_address = $urandom;
        c.sample_value = $urandom;
        c.magnitude = mag;
        c.phase = ph;
        send_item(c);
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FRAME_COUNT)
            frame_count_reg = value;
        else
            channel_count_reg = value[1:0];
    endtask

    task automatic apply_setting(int unsigned frames, int unsigned chans);
        drain();
        write_reg(REG_FRAME_COUNT, frames);
        write_reg(REG_CHANNEL_COUNT, chans);
        settings_used++;
    endtask

    task automatic random_item();
        int unsigned     pick;
        int unsigned     region;
        logic [MAG_W-1:0]   mag;
        logic [PHASE_W-1:0] ph;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            region = active_channels() * active_frames();
            if (pick < 28)
                send_item(make_load($urandom_range(0, region - 1), $urandom));
            else
                send_item(make_load($urandom_range(0, STORE_WORDS - 1), $urandom));
        end
        else
        begin
            mag = $urandom;
            ph = $urandom;
            if (pick < 85)
                ph[PHASE_W-1] = 1'b0;
            if (pick >= 95)
                ph = (pick[0]) ? 17'h0FFFF : 17'h10000;
            play_frame(mag, ph);
        end
    endtask

    // defaults after reset: one frame, mono; field extremes
    task automatic test_reset_state();
        send_item(make_load(0, 16'h7FFF));
        play_frame(16'h0000, 17'h00000);
        play_frame(16'hFFFF, 17'h0FFFF);
        send_item(make_load(0, 16'h8000));
        play_frame(16'h0000, 17'h10000);
        play_frame(16'h2000, 17'h1FFFF);
        send_item(make_load(STORE_WORDS - 1, 16'h5A5A));
        send_item(make_load(1, 16'hA5A5));
        play_frame(16'hE000, 17'h08000);
    endtask

    // zero and out-of-range register values
    task automatic test_register_corners();
        apply_setting(0, 0);
        play_frame(16'hFFFF, 17'h0FFFF);
        play_frame(16'h0000, 17'h00001);
        apply_setting(262143, 3);
        play_frame(16'hFFFF, 17'h0FFFF);
        play_frame(16'h0000, 17'h00000);
        play_frame(16'h6000, 17'h10000);
        apply_setting(LSSP_MAX_FRAMES, 2);
        play_frame(16'hE000, 17'h08000);
        play_frame(16'h1FFF, 17'h0C000);
    endtask

    // clock runs past a frame count that is then lowered
    task automatic test_clock_wrap();
        apply_setting(100, 1);
        repeat (70) play_frame($urandom, {1'b0, 16'($urandom)});
        apply_setting(7, 1);
        repeat (12) random_item();
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        apply_setting(16, 2);
        sender_calm = 1'b1;
        hold_request = 400;
        repeat (30) random_item();
        sender_calm = 1'b0;
    endtask

    task automatic test_random_loops();
        int unsigned loop_frames [13];
        int unsigned loop_chans [13];
        loop_frames = '{1, 2, 5, 16, 100, 1000, LSSP_MAX_FRAMES, LSSP_MAX_FRAMES, 3,
                        4096, 65536, $urandom_range(1, LSSP_MAX_FRAMES), 200000};
        loop_chans = '{1, 2, 1, 2, 1, 2, 2, 1, 3, 0, 2, $urandom_range(1, 2), 1};
        for (int i = 0; i < 13; i++)
        begin
            apply_setting(loop_frames[i], loop_chans[i]);
            sender_calm = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            repeat (LOOP_ITEMS) random_item();
        end
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (receiver_calm || $urandom_range(0, 99) < 70)
            rsp_ch.ready <= 1'b1;
        else
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin : check_frames
        stereo_frame_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_frames.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: frame with none expected: left %h right %h",
                             $realtime, rsp_ch.left_sample, rsp_ch.right_sample);
            end
            else
            begin
                want = expected_frames.pop_front();
                frames_checked++;
                if (rsp_ch.left_sample !== want.left_sample ||
                    rsp_ch.right_sample !== want.right_sample)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: frame %0d: left exp %h got %h, right exp %h got %h",
                                 $realtime, frames_checked, want.left_sample,
                                 rsp_ch.left_sample, want.right_sample,
                                 rsp_ch.right_sample);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: %0d cycles without an item, %0d frames outstanding",
                     idle_cycles, expected_frames.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.func = FUNC_LOAD;
        cmd_ch.sample_address = '0;
        cmd_ch.sample_value = '0;
        cmd_ch.magnitude = '0;
        cmd_ch.phase = '0;
        rsp_ch.ready = 1'b0;
        play_clock = 0;
        frame_count_reg = 1;
        channel_count_reg = 1;
        errors = 0;
        frames_checked = 0;
        loads_sent = 0;
        renders_sent = 0;
        settings_used = 0;
        idle_cycles = 0;
        stall_left = 0;
        hold_request = 0;
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_register_corners();
        test_clock_wrap();
        test_backpressure();
        test_random_loops();
        drain();

        $display("Sent %0d loads and %0d renders across %0d loop settings;",
                 loads_sent, renders_sent, settings_used);
        $display("compared %0d frames, %0d failures.", frames_checked, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/lssp_pkg.sv
design/lssp_ifs.sv
design/lssp_mod.sv
design/lssp_store.sv
design/loop_segment_sample_player.sv
sim/loop_segment_sample_player_tb.sv
